[src/sxt_pkg.sv]
// shared types, character codes and classification functions for the s-expression tokenizer
package sxt_pkg;

   localparam int TOKEN_BUFFER_DEFAULT = 32;
   localparam int CHAR_W = 8;
   localparam int KIND_W = 2;
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

   localparam logic [CHAR_W-1:0] CHAR_AT       = 8'h40;
   localparam logic [CHAR_W-1:0] CHAR_COMMA    = 8'h2C;
   localparam logic [CHAR_W-1:0] CHAR_LPAREN   = 8'h28;
   localparam logic [CHAR_W-1:0] CHAR_RPAREN   = 8'h29;
   localparam logic [CHAR_W-1:0] CHAR_ZERO     = 8'h30;
   localparam logic [CHAR_W-1:0] CHAR_NINE     = 8'h39;
   localparam logic [CHAR_W-1:0] CHAR_DQUOTE   = 8'h22;
   localparam logic [CHAR_W-1:0] CHAR_SPACE    = 8'h20;
   localparam logic [CHAR_W-1:0] CHAR_NEWLINE  = 8'h0A;
   localparam logic [CHAR_W-1:0] CHAR_QUOTE    = 8'h27;
   localparam logic [CHAR_W-1:0] CHAR_BACKTICK = 8'h60;
   localparam logic [CHAR_W-1:0] CHAR_MINUS    = 8'h2D;
   localparam logic [CHAR_W-1:0] CHAR_PLUS     = 8'h2B;
   localparam logic [CHAR_W-1:0] CHAR_STAR     = 8'h2A;
   localparam logic [CHAR_W-1:0] CHAR_SLASH    = 8'h2F;
   localparam logic [CHAR_W-1:0] CHAR_EQUAL    = 8'h3D;
   localparam logic [CHAR_W-1:0] CHAR_PERCENT  = 8'h25;
   localparam logic [CHAR_W-1:0] CHAR_CARET    = 8'h5E;
   localparam logic [CHAR_W-1:0] CHAR_AMP      = 8'h26;
   localparam logic [CHAR_W-1:0] CHAR_BAR      = 8'h7C;
   localparam logic [CHAR_W-1:0] CHAR_BANG     = 8'h21;

   localparam logic [KIND_W-1:0] KIND_PUNCT  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_STRING = 2'd1;
   localparam logic [KIND_W-1:0] KIND_NUMBER = 2'd2;
   localparam logic [KIND_W-1:0] KIND_SYMBOL = 2'd3;

   typedef enum logic [2:0] {
      MODE_IDLE    = 3'd0,
      MODE_COMMA   = 3'd1,
      MODE_STRING  = 3'd2,
      MODE_NUMBER  = 3'd3,
      MODE_SYMBOL  = 3'd4,
      MODE_STRDROP = 3'd5
   } mode_type;

   typedef struct packed {
      logic [CHAR_W-1:0] token_char;
      logic [KIND_W-1:0] token_kind;
      logic              last_of_token;
   } result_type;

   function automatic logic is_blank(input logic [CHAR_W-1:0] c);
      return (c == CHAR_SPACE) || (c == CHAR_NEWLINE);
   endfunction

   function automatic logic is_paren(input logic [CHAR_W-1:0] c);
      return (c == CHAR_LPAREN) || (c == CHAR_RPAREN);
   endfunction

   function automatic logic is_numeral(input logic [CHAR_W-1:0] c);
      return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
   endfunction

   function automatic logic is_single(input logic [CHAR_W-1:0] c);
      return is_paren(c) || (c == CHAR_QUOTE) || (c == CHAR_BACKTICK) ||
             (c == CHAR_MINUS) || (c == CHAR_PLUS) || (c == CHAR_STAR) ||
             (c == CHAR_SLASH) || (c == CHAR_EQUAL) || (c == CHAR_PERCENT) ||
             (c == CHAR_CARET) || (c == CHAR_AMP) || (c == CHAR_BAR) ||
             (c == CHAR_BANG);
   endfunction

   function automatic logic [KIND_W-1:0] mode_kind(input mode_type m);
      logic [KIND_W-1:0] k;
      case (m)
         MODE_STRING: k = KIND_STRING;
         MODE_NUMBER: k = KIND_NUMBER;
         MODE_SYMBOL: k = KIND_SYMBOL;
         default:     k = KIND_PUNCT;
      endcase
      return k;
   endfunction

   function automatic result_type make_result(input logic [CHAR_W-1:0] c,
                                              input logic [KIND_W-1:0] k,
                                              input logic last);
      result_type r;
      r.token_char    = c;
      r.token_kind    = k;
      r.last_of_token = last;
      return r;
   endfunction

endpackage

[src/s_expression_tokenizer_unit.sv]
// s-expression tokenizer: one source character in, up to two token characters out
// output: token characters are written into the registered result queue and offered on the result side from its head
// throughput: one request per cycle while the queue has room; a request that yields two characters fills two
// queue entries, and requests stall while the four-entry result queue holds three or more
// reset: synchronous, clears lexer mode, held character, token length and the result queue
module s_expression_tokenizer_unit #(
   parameter int TOKEN_BUFFER = sxt_pkg::TOKEN_BUFFER_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [sxt_pkg::CHAR_W-1:0] req_tdata,   // [7:0] input_char
   input  logic                      req_tlast,    // end_of_input
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [sxt_pkg::CHAR_W-1:0] rsp_tdata,   // [7:0] token_char
   output logic [sxt_pkg::KIND_W-1:0] rsp_tuser,   // [1:0] token_kind
   output logic                      rsp_tlast     // last_of_token
);
   import sxt_pkg::*;

   localparam int LEN_W = $clog2(TOKEN_BUFFER);
   localparam logic [LEN_W:0] TOKEN_CAP = (LEN_W+1)'(TOKEN_BUFFER - 1);

   mode_type          mode_ff, mode_in;
   logic [CHAR_W-1:0] held_char_ff, held_char_in;
   logic              held_valid_ff, held_valid_in;
   logic [LEN_W-1:0]  len_ff, len_in;

   result_type        slot [2];
   logic [1:0]        emit_cnt;
   logic              do_start;
   logic              do_accept;
   logic [LEN_W:0]    len_next;
   logic [KIND_W-1:0] acc_kind;
   logic [CHAR_W-1:0] c;

   result_type             queue_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_PTR_W:0]   count_ff, count_in;
   logic                   req_fire;
   logic                   rsp_fire;

   assign c          = req_tdata;
   assign req_tready = (count_ff <= (QUEUE_PTR_W+1)'(QUEUE_DEPTH - 2));
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_tvalid = (count_ff != '0);
   assign rsp_fire   = rsp_tvalid && rsp_tready;
   assign rsp_tdata  = queue_ff[rd_ptr_ff].token_char;
   assign rsp_tuser  = queue_ff[rd_ptr_ff].token_kind;
   assign rsp_tlast  = queue_ff[rd_ptr_ff].last_of_token;

   always_comb begin
      mode_in       = mode_ff;
      held_char_in  = held_char_ff;
      held_valid_in = held_valid_ff;
      len_in        = len_ff;
      slot[0]       = make_result(CHAR_COMMA, KIND_PUNCT, 1'b0);
      slot[1]       = make_result(CHAR_COMMA, KIND_PUNCT, 1'b0);
      emit_cnt      = 2'd0;
      do_start      = 1'b0;
      do_accept     = 1'b0;
      len_next      = '0;
      acc_kind      = KIND_PUNCT;

      if (req_tlast) begin
         if (held_valid_ff) begin
            slot[emit_cnt[0]] = make_result(held_char_ff, mode_kind(mode_ff), 1'b1);
            emit_cnt = emit_cnt + 2'd1;
         end
         mode_in       = MODE_IDLE;
         held_valid_in = 1'b0;
         len_in        = '0;
      end else begin
         case (mode_ff)
            MODE_COMMA: begin
               if (c == CHAR_AT) begin
                  slot[0]       = make_result(CHAR_COMMA, KIND_PUNCT, 1'b0);
                  slot[1]       = make_result(CHAR_AT, KIND_PUNCT, 1'b1);
                  emit_cnt      = 2'd2;
                  mode_in       = MODE_IDLE;
                  held_valid_in = 1'b0;
                  len_in        = '0;
               end else begin
                  slot[0]  = make_result(CHAR_COMMA, KIND_PUNCT, 1'b1);
                  emit_cnt = 2'd1;
                  do_start = 1'b1;
               end
            end
            MODE_STRING: begin
               if (c == CHAR_DQUOTE) begin
                  if (held_valid_ff) begin
                     slot[0]  = make_result(held_char_ff, KIND_STRING, 1'b1);
                     emit_cnt = 2'd1;
                  end
                  mode_in       = MODE_IDLE;
                  held_valid_in = 1'b0;
                  len_in        = '0;
               end else begin
                  do_accept = 1'b1;
               end
            end
            MODE_NUMBER, MODE_SYMBOL: begin
               if ((mode_ff == MODE_NUMBER) ? is_numeral(c)
                                            : !(is_blank(c) || is_paren(c))) begin
                  do_accept = 1'b1;
               end else begin
                  if (held_valid_ff) begin
                     slot[0]  = make_result(held_char_ff, mode_kind(mode_ff), 1'b1);
                     emit_cnt = 2'd1;
                  end
                  do_start = 1'b1;
               end
            end
            MODE_STRDROP: begin
               mode_in       = MODE_IDLE;
               held_valid_in = 1'b0;
               len_in        = '0;
            end
            default: begin
               do_start = 1'b1;
            end
         endcase

         if (do_start) begin
            mode_in       = MODE_IDLE;
            held_valid_in = 1'b0;
            len_in        = '0;
            if (is_blank(c)) begin
               mode_in = MODE_IDLE;
            end else if (c == CHAR_COMMA) begin
               mode_in       = MODE_COMMA;
               held_char_in  = c;
               held_valid_in = 1'b1;
            end else if (is_single(c)) begin
               slot[emit_cnt[0]] = make_result(c, KIND_PUNCT, 1'b1);
               emit_cnt = emit_cnt + 2'd1;
            end else if (c == CHAR_DQUOTE) begin
               mode_in   = MODE_STRING;
               do_accept = 1'b1;
            end else if (is_numeral(c)) begin
               mode_in   = MODE_NUMBER;
               do_accept = 1'b1;
            end else begin
               mode_in   = MODE_SYMBOL;
               do_accept = 1'b1;
            end
         end

         if (do_accept) begin
            acc_kind = mode_kind(mode_in);
            if (held_valid_in) begin
               slot[emit_cnt[0]] = make_result(held_char_in, acc_kind, 1'b0);
               emit_cnt = emit_cnt + 2'd1;
            end
            len_next = {1'b0, len_in} + (LEN_W+1)'(1);
            if (len_next >= TOKEN_CAP) begin
               slot[emit_cnt[0]] = make_result(c, acc_kind, 1'b1);
               emit_cnt = emit_cnt + 2'd1;
               held_valid_in = 1'b0;
               len_in        = '0;
               mode_in       = (mode_in == MODE_STRING) ? MODE_STRDROP : MODE_IDLE;
            end else begin
               len_in        = len_next[LEN_W-1:0];
               held_char_in  = c;
               held_valid_in = 1'b1;
            end
         end
      end
   end

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (req_fire) begin
         wr_ptr_in = wr_ptr_ff + QUEUE_PTR_W'(emit_cnt);
         count_in  = count_in + (QUEUE_PTR_W+1)'(emit_cnt);
      end
      if (rsp_fire) begin
         rd_ptr_in = rd_ptr_ff + QUEUE_PTR_W'(1);
         count_in  = count_in - (QUEUE_PTR_W+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= MODE_IDLE;
         held_char_ff  <= '0;
         held_valid_ff <= 1'b0;
         len_ff        <= '0;
         wr_ptr_ff     <= '0;
         rd_ptr_ff     <= '0;
         count_ff      <= '0;
      end else begin
         if (req_fire) begin
            mode_ff       <= mode_in;
            held_char_ff  <= held_char_in;
            held_valid_ff <= held_valid_in;
            len_ff        <= len_in;
         end
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire && (emit_cnt != 2'd0)) begin
         queue_ff[wr_ptr_ff] <= slot[0];
      end
      if (req_fire && (emit_cnt == 2'd2)) begin
         queue_ff[wr_ptr_ff + QUEUE_PTR_W'(1)] <= slot[1];
      end
   end

endmodule

[bench/testbench.sv]
// self-checking bench for the s-expression tokenizer: directed and random source text against a local lexer
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import sxt_pkg::*;

   localparam int CAP = TOKEN_BUFFER_DEFAULT - 1;
   localparam int RANDOM_ITEMS = 1650;

   typedef struct packed {
      logic [CHAR_W-1:0] ch;
      logic              eoi;
   } source_item_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_tvalid = 1'b0;
   logic              req_tready;
   logic [CHAR_W-1:0] req_tdata = '0;
   logic              req_tlast = 1'b0;
   logic              rsp_tvalid;
   logic              rsp_tready = 1'b0;
   logic [CHAR_W-1:0] rsp_tdata;
   logic [KIND_W-1:0] rsp_tuser;
   logic              rsp_tlast;

   source_item_type char_feed[$];
   result_type expected_tokens[$];

   int accepted_count = 0;
   int mismatches = 0;
   int hold_left = 0;
   bit hold_done = 1'b0;

   // local copy of the lexer state
   mode_type          lex_mode = MODE_IDLE;
   logic [CHAR_W-1:0] held_ch = '0;
   logic              held_on = 1'b0;
   logic [4:0]        tok_len = '0;

   s_expression_tokenizer_unit u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always #1 clock = ~clock;

   function automatic bit char_blank(input logic [CHAR_W-1:0] c);
      return c == CHAR_SPACE || c == CHAR_NEWLINE;
   endfunction

   function automatic bit char_paren(input logic [CHAR_W-1:0] c);
      return c == CHAR_LPAREN || c == CHAR_RPAREN;
   endfunction

   function automatic bit char_digit(input logic [CHAR_W-1:0] c);
      return c >= CHAR_ZERO && c <= CHAR_NINE;
   endfunction

   function automatic bit char_lone(input logic [CHAR_W-1:0] c);
      case (c)
         CHAR_LPAREN, CHAR_RPAREN, CHAR_QUOTE, CHAR_BACKTICK, CHAR_MINUS, CHAR_PLUS,
         CHAR_STAR, CHAR_SLASH, CHAR_EQUAL, CHAR_PERCENT, CHAR_CARET, CHAR_AMP,
         CHAR_BAR, CHAR_BANG: return 1'b1;
         default: return 1'b0;
      endcase
   endfunction

   function automatic logic [KIND_W-1:0] kind_of_mode(input mode_type m);
      case (m)
         MODE_STRING: return KIND_STRING;
         MODE_NUMBER: return KIND_NUMBER;
         MODE_SYMBOL: return KIND_SYMBOL;
         default:     return KIND_PUNCT;
      endcase
   endfunction

   function automatic void push_token(input logic [CHAR_W-1:0] ch, input logic [KIND_W-1:0] kind,
                                      input logic last);
      result_type r;
      r.token_char    = ch;
      r.token_kind    = kind;
      r.last_of_token = last;
      expected_tokens.push_back(r);
   endfunction

   function automatic void drop_token();
      held_on  = 1'b0;
      tok_len  = '0;
      lex_mode = MODE_IDLE;
   endfunction

   function automatic void close_token();
      if (held_on)
         push_token(held_ch, kind_of_mode(lex_mode), 1'b1);
      drop_token();
   endfunction

   function automatic void grow_token(input logic [CHAR_W-1:0] c);
      logic [KIND_W-1:0] kind;
      bit was_string;
      kind = kind_of_mode(lex_mode);
      if (held_on)
         push_token(held_ch, kind, 1'b0);
      tok_len = tok_len + 5'd1;
      if (tok_len >= 5'(CAP)) begin
         was_string = (lex_mode == MODE_STRING);
         push_token(c, kind, 1'b1);
         drop_token();
         if (was_string)
            lex_mode = MODE_STRDROP;
      end else begin
         held_ch = c;
         held_on = 1'b1;
      end
   endfunction

   function automatic void open_token(input logic [CHAR_W-1:0] c);
      drop_token();
      if (char_blank(c))
         return;
      if (c == CHAR_COMMA) begin
         lex_mode = MODE_COMMA;
         held_ch  = c;
         held_on  = 1'b1;
      end else if (char_lone(c)) begin
         push_token(c, KIND_PUNCT, 1'b1);
      end else if (c == CHAR_DQUOTE) begin
         lex_mode = MODE_STRING;
         grow_token(c);
      end else if (char_digit(c)) begin
         lex_mode = MODE_NUMBER;
         grow_token(c);
      end else begin
         lex_mode = MODE_SYMBOL;
         grow_token(c);
      end
   endfunction

   function automatic void lex_char(input logic [CHAR_W-1:0] c, input logic eoi);
      if (eoi) begin
         close_token();
         return;
      end
      case (lex_mode)
         MODE_COMMA: begin
            if (c == CHAR_AT) begin
               push_token(CHAR_COMMA, KIND_PUNCT, 1'b0);
               push_token(CHAR_AT, KIND_PUNCT, 1'b1);
               drop_token();
            end else begin
               push_token(CHAR_COMMA, KIND_PUNCT, 1'b1);
               open_token(c);
            end
         end
         MODE_STRING: begin
            if (c == CHAR_DQUOTE)
               close_token();
            else
               grow_token(c);
         end
         MODE_NUMBER: begin
            if (char_digit(c)) begin
               grow_token(c);
            end else begin
               close_token();
               open_token(c);
            end
         end
         MODE_SYMBOL: begin
            if (char_blank(c) || char_paren(c)) begin
               close_token();
               open_token(c);
            end else begin
               grow_token(c);
            end
         end
         MODE_STRDROP: drop_token();
         default: open_token(c);
      endcase
   endfunction

   function automatic void add_char(input logic [CHAR_W-1:0] c);
      source_item_type it;
      it.ch  = c;
      it.eoi = 1'b0;
      char_feed.push_back(it);
   endfunction

   function automatic void add_end();
      source_item_type it;
      it.ch  = CHAR_W'($urandom_range(0, 255));
      it.eoi = 1'b1;
      char_feed.push_back(it);
   endfunction

   function automatic void add_text(input string s);
      for (int i = 0; i < s.len(); i++)
         add_char(s[i]);
   endfunction

   function automatic int token_size();
      if ($urandom_range(0, 9) == 0)
         return $urandom_range(28, 34);
      return $urandom_range(0, 8);
   endfunction

   function automatic logic [CHAR_W-1:0] lone_char();
      case ($urandom_range(0, 13))
         0:  return CHAR_LPAREN;
         1:  return CHAR_RPAREN;
         2:  return CHAR_QUOTE;
         3:  return CHAR_BACKTICK;
         4:  return CHAR_MINUS;
         5:  return CHAR_PLUS;
         6:  return CHAR_STAR;
         7:  return CHAR_SLASH;
         8:  return CHAR_EQUAL;
         9:  return CHAR_PERCENT;
         10: return CHAR_CARET;
         11: return CHAR_AMP;
         12: return CHAR_BAR;
         default: return CHAR_BANG;
      endcase
   endfunction

   function automatic void add_random_token();
      int pick;
      int n;
      logic [CHAR_W-1:0] c;
      pick = $urandom_range(0, 99);
      n = token_size();
      if (pick < 20) begin
         add_char(CHAR_DQUOTE);
         for (int i = 0; i < n; i++) begin
            do c = CHAR_W'($urandom_range(0, 255)); while (c == CHAR_DQUOTE);
            add_char(c);
         end
         if ($urandom_range(0, 4) != 0)
            add_char(CHAR_DQUOTE);
      end else if (pick < 38) begin
         for (int i = 0; i <= n; i++)
            add_char(CHAR_ZERO + CHAR_W'($urandom_range(0, 9)));
      end else if (pick < 58) begin
         do c = CHAR_W'($urandom_range(0, 255));
         while (char_blank(c) || char_lone(c) || char_digit(c) || c == CHAR_COMMA ||
                c == CHAR_DQUOTE);
         add_char(c);
         for (int i = 0; i < n; i++) begin
            do c = CHAR_W'($urandom_range(0, 255)); while (char_blank(c) || char_paren(c));
            add_char(c);
         end
      end else if (pick < 70) begin
         add_char(lone_char());
      end else if (pick < 76) begin
         add_char(CHAR_COMMA);
         if ($urandom_range(0, 1) == 0)
            add_char(CHAR_AT);
      end else if (pick < 88) begin
         add_char($urandom_range(0, 1) ? CHAR_SPACE : CHAR_NEWLINE);
      end else if (pick < 93) begin
         add_end();
      end else begin
         add_char(CHAR_W'($urandom_range(0, 255)));
      end
      if ($urandom_range(0, 1) == 0)
         add_char($urandom_range(0, 3) ? CHAR_SPACE : CHAR_NEWLINE);
   endfunction

   // no idling on either side while the middle of the run goes through
   function automatic bit idle_roll();
      if (accepted_count >= 400 && accepted_count < 800)
         return 1'b0;
      return $urandom_range(0, 99) < 8;
   endfunction

   always @(posedge clock) begin
      source_item_type it;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         if (char_feed.size() != 0 && !idle_roll()) begin
            it = char_feed.pop_front();
            req_tdata  <= it.ch;
            req_tlast  <= it.eoi;
            req_tvalid <= 1'b1;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // receiver with one long hold-off so the result queue fills and stalls requests
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else if (!hold_done && accepted_count >= 1000) begin
         hold_done  <= 1'b1;
         hold_left  <= 60;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= !idle_roll();
      end
   end

   always @(posedge clock) begin
      result_type want;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            lex_char(req_tdata, req_tlast);
            accepted_count <= accepted_count + 1;
         end
         if (rsp_tvalid && rsp_tready) begin
            if (expected_tokens.size() == 0) begin
               mismatches = mismatches + 1;
               if (mismatches <= 10)
                  $display("unexpected token char %h kind %0d last %0d",
                           rsp_tdata, rsp_tuser, rsp_tlast);
            end else begin
               want = expected_tokens.pop_front();
               if (rsp_tdata !== want.token_char || rsp_tuser !== want.token_kind ||
                   rsp_tlast !== want.last_of_token) begin
                  mismatches = mismatches + 1;
                  if (mismatches <= 10)
                     $display({"mismatch: got char %h kind %0d last %0d, ",
                               "want char %h kind %0d last %0d"},
                              rsp_tdata, rsp_tuser, rsp_tlast,
                              want.token_char, want.token_kind, want.last_of_token);
               end
            end
         end
      end
   end

   initial begin
      add_text("(,@x ,9)");
      add_text("\"a\"");
      add_text("\"h");
      add_end();
      add_end();
      add_text("@ ");
      add_char(8'hFF);
      add_char(8'h00);
      add_end();
      add_text("+-");
      while (char_feed.size() < RANDOM_ITEMS + 22)
         add_random_token();

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      wait (char_feed.size() == 0);
      wait (!req_tvalid);
      wait (expected_tokens.size() == 0);
      repeat (8) @(posedge clock);
      if (mismatches == 0 && expected_tokens.size() == 0)
         $display("s_expression_tokenizer_unit test passed");
      else
         $display("s_expression_tokenizer_unit test failed");
      $finish;
   end

   initial begin
      #400us;
      $display("s_expression_tokenizer_unit test failed");
      $finish;
   end

endmodule

[files.f]
src/sxt_pkg.sv
src/s_expression_tokenizer_unit.sv
bench/testbench.sv
